// ===== src/kse_pkg.sv =====
`timescale 1ns / 1ps
// Package for the keyboard map keycode extractor: parser phase codes,
// record kind codes, map constants and the arrow slot table.
// No dependencies.
package kse_pkg;

  typedef enum logic [3:0] {
    PH_HDR_HI    = 4'd0,
    PH_HDR_LO    = 4'd1,
    PH_NUM_MODS  = 4'd2,
    PH_MOD_CODE  = 4'd3,
    PH_MOD_COUNT = 4'd4,
    PH_MOD_KEY   = 4'd5,
    PH_NUM_KEYS  = 4'd6,
    PH_KEY_MASK  = 4'd7,
    PH_PAIR_SET  = 4'd8,
    PH_PAIR_CODE = 4'd9,
    PH_DONE      = 4'd10
  } phase_t;

  typedef enum logic [1:0] {
    KIND_MOD_LEFT  = 2'd0,
    KIND_MOD_RIGHT = 2'd1,
    KIND_ARROW     = 2'd2,
    KIND_END       = 2'd3
  } record_kind_t;

  localparam logic [15:0] NUM_MODIFIERS = 16'd16;
  localparam logic [15:0] UNBOUND_MASK  = 16'h00FF;
  localparam logic [15:0] SYMBOL_SET    = 16'h0001;
  localparam logic [7:0]  ARROW_BASE    = 8'hAC;
  localparam logic [1:0]  LOCK_SHIFT    = 2'b01;
  localparam logic [1:0]  LOCK_ALPHA    = 2'b10;
  localparam logic [1:0]  LOCK_BOTH     = 2'b11;

  // Arrow symbol offset to slot: Left 0, Up 3, Right 1, Down 2.
  function automatic logic [3:0] arrow_slot(input logic [1:0] offset);
    logic [3:0] s;
    case (offset)
      2'd0:    s = 4'd0;
      2'd1:    s = 4'd3;
      2'd2:    s = 4'd1;
      2'd3:    s = 4'd2;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== src/keymap_stream_keycode_extractor.sv =====
`timescale 1ns / 1ps
// Keyboard map keycode extractor: parses a keyboard map byte stream and
// reports modifier keycodes, arrow keycodes and the end of the map.
// Depends on kse_pkg.
//
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------
//  byte    | byte_valid, byte_stall    | data_byte, start_of_map
//  record  | record_valid, record_stall| record_kind, slot, keycode, map_done
//
// One byte per cycle sustained while byte_stall is low; the record of a byte, if it has
// one, goes through the input register, then the parser and result register, before it
// is offered on the record port.
// Parser state updates in one pass of logic between the two registers.
// Reset (rst, synchronous) empties both registers and returns the parser to
// the header. A stalled record holds the parser only when the next byte
// would produce a record too; bytes without a record keep flowing.
module keymap_stream_keycode_extractor (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] data_byte,
  input  logic       start_of_map,
  output logic       record_valid,
  input  logic       record_stall,
  output logic [1:0] record_kind,
  output logic [3:0] slot,
  output logic [7:0] keycode,
  output logic       map_done
);

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;

  // Parser state.
  kse_pkg::phase_t phase, phase_next;
  logic        wide_numbers, wide_numbers_next;
  logic        high_byte_pending, high_byte_pending_next;
  logic [7:0]  held_high_byte, held_high_byte_next;
  logic [15:0] modifiers_left, modifiers_left_next;
  logic [15:0] modifier_code, modifier_code_next;
  logic [15:0] mod_keycodes_left, mod_keycodes_left_next;
  logic        first_of_modifier, first_of_modifier_next;
  logic [15:0] keys_total, keys_total_next;
  logic [15:0] key_index, key_index_next;
  logic [16:0] pairs_left, pairs_left_next;
  logic [1:0]  pair_position, pair_position_next;
  logic [1:0]  shift_lock_bits, shift_lock_bits_next;
  logic [15:0] held_char_set, held_char_set_next;

  // State as seen by the current byte (start_of_map restarts everything).
  kse_pkg::phase_t cur_phase;
  logic        cur_wide, cur_pending, cur_first;
  logic [7:0]  cur_held;
  logic [15:0] cur_mods_left, cur_mod_code, cur_mod_keys, cur_keys_total;
  logic [15:0] cur_key_index, cur_char_set;
  logic [16:0] cur_pairs;
  logic [1:0]  cur_pair_pos, cur_lock;

  logic        take;
  logic [15:0] num;
  logic [15:0] count_val;
  logic [4:0]  mask_ones;
  logic [15:0] dec16;
  logic        selected;

  logic        emit_valid, emit_done;
  logic [1:0]  emit_kind;
  logic [3:0]  emit_slot;
  logic [7:0]  emit_code;
  logic        process;

  function automatic logic [4:0] popcount16(input logic [15:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 16; i++) begin
      n = n + {4'd0, v[i]};
    end
    return n;
  endfunction

  assign process    = in_valid_q && (!record_valid || !record_stall || !emit_valid);
  assign byte_stall = in_valid_q && !process;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!byte_stall) begin
      in_valid_q <= byte_valid;
    end
    if (byte_valid && !byte_stall) begin
      in_byte_q  <= data_byte;
      in_start_q <= start_of_map;
    end
  end

  always_comb begin
    if (in_start_q) begin
      cur_phase      = kse_pkg::PH_HDR_HI;
      cur_wide       = 1'b0;
      cur_pending    = 1'b0;
      cur_held       = 8'd0;
      cur_mods_left  = 16'd0;
      cur_mod_code   = 16'd0;
      cur_mod_keys   = 16'd0;
      cur_first      = 1'b1;
      cur_keys_total = 16'd0;
      cur_key_index  = 16'd0;
      cur_pairs      = 17'd0;
      cur_pair_pos   = 2'd0;
      cur_lock       = 2'd0;
      cur_char_set   = 16'd0;
    end else begin
      cur_phase      = phase;
      cur_wide       = wide_numbers;
      cur_pending    = high_byte_pending;
      cur_held       = held_high_byte;
      cur_mods_left  = modifiers_left;
      cur_mod_code   = modifier_code;
      cur_mod_keys   = mod_keycodes_left;
      cur_first      = first_of_modifier;
      cur_keys_total = keys_total;
      cur_key_index  = key_index;
      cur_pairs      = pairs_left;
      cur_pair_pos   = pair_position;
      cur_lock       = shift_lock_bits;
      cur_char_set   = held_char_set;
    end

    phase_next             = cur_phase;
    wide_numbers_next      = cur_wide;
    high_byte_pending_next = cur_pending;
    held_high_byte_next    = cur_held;
    modifiers_left_next    = cur_mods_left;
    modifier_code_next     = cur_mod_code;
    mod_keycodes_left_next = cur_mod_keys;
    first_of_modifier_next = cur_first;
    keys_total_next        = cur_keys_total;
    key_index_next         = cur_key_index;
    pairs_left_next        = cur_pairs;
    pair_position_next     = cur_pair_pos;
    shift_lock_bits_next   = cur_lock;
    held_char_set_next     = cur_char_set;

    emit_valid = 1'b0;
    emit_done  = 1'b0;
    emit_kind  = kse_pkg::KIND_MOD_LEFT;
    emit_slot  = 4'd0;
    emit_code  = 8'd0;
    take       = 1'b0;
    selected   = 1'b0;

    num       = cur_wide ? {cur_held, in_byte_q} : {8'd0, in_byte_q};
    // With 2-byte numbers a negative count means zero.
    count_val = (cur_wide && num[15]) ? 16'd0 : num;
    mask_ones = popcount16(num);
    dec16     = 16'd0;

    case (cur_phase)
      kse_pkg::PH_HDR_HI: begin
        held_high_byte_next = in_byte_q;
        phase_next          = kse_pkg::PH_HDR_LO;
      end
      kse_pkg::PH_HDR_LO: begin
        wide_numbers_next   = (cur_held != 8'd0) || (in_byte_q != 8'd0);
        held_high_byte_next = 8'd0;
        phase_next          = kse_pkg::PH_NUM_MODS;
      end
      kse_pkg::PH_DONE: begin
        phase_next = kse_pkg::PH_DONE;
      end
      kse_pkg::PH_NUM_MODS, kse_pkg::PH_MOD_CODE, kse_pkg::PH_MOD_COUNT,
      kse_pkg::PH_MOD_KEY, kse_pkg::PH_NUM_KEYS, kse_pkg::PH_KEY_MASK,
      kse_pkg::PH_PAIR_SET, kse_pkg::PH_PAIR_CODE: begin
        if (cur_wide && !cur_pending) begin
          held_high_byte_next    = in_byte_q;
          high_byte_pending_next = 1'b1;
        end else begin
          high_byte_pending_next = 1'b0;
          take                   = 1'b1;
        end
      end
      default: begin
        phase_next = kse_pkg::PH_DONE;
      end
    endcase

    if (take) begin
      case (cur_phase)
        kse_pkg::PH_NUM_MODS: begin
          modifiers_left_next = count_val;
          phase_next = (count_val == 16'd0) ? kse_pkg::PH_NUM_KEYS : kse_pkg::PH_MOD_CODE;
        end
        kse_pkg::PH_MOD_CODE: begin
          modifier_code_next = num;
          phase_next         = kse_pkg::PH_MOD_COUNT;
        end
        kse_pkg::PH_MOD_COUNT: begin
          first_of_modifier_next = 1'b1;
          if (count_val == 16'd0) begin
            dec16               = cur_mods_left - 16'd1;
            modifiers_left_next = dec16;
            phase_next = (dec16 == 16'd0) ? kse_pkg::PH_NUM_KEYS : kse_pkg::PH_MOD_CODE;
          end else begin
            mod_keycodes_left_next = count_val;
            phase_next             = kse_pkg::PH_MOD_KEY;
          end
        end
        kse_pkg::PH_MOD_KEY: begin
          if (cur_mod_code < kse_pkg::NUM_MODIFIERS) begin
            emit_valid = 1'b1;
            emit_kind  = cur_first ? kse_pkg::KIND_MOD_LEFT : kse_pkg::KIND_MOD_RIGHT;
            emit_slot  = cur_mod_code[3:0];
            emit_code  = num[7:0];
          end
          first_of_modifier_next = 1'b0;
          mod_keycodes_left_next = cur_mod_keys - 16'd1;
          if (cur_mod_keys == 16'd1) begin
            dec16               = cur_mods_left - 16'd1;
            modifiers_left_next = dec16;
            phase_next = (dec16 == 16'd0) ? kse_pkg::PH_NUM_KEYS : kse_pkg::PH_MOD_CODE;
          end
        end
        kse_pkg::PH_NUM_KEYS: begin
          keys_total_next = count_val;
          key_index_next  = 16'd0;
          if (count_val == 16'd0) begin
            phase_next = kse_pkg::PH_DONE;
            emit_done  = 1'b1;
          end else begin
            phase_next = kse_pkg::PH_KEY_MASK;
          end
        end
        kse_pkg::PH_KEY_MASK: begin
          if (num == kse_pkg::UNBOUND_MASK) begin
            dec16          = cur_key_index + 16'd1;
            key_index_next = dec16;
            if (dec16 == cur_keys_total) begin
              phase_next = kse_pkg::PH_DONE;
              emit_done  = 1'b1;
            end else begin
              phase_next = kse_pkg::PH_KEY_MASK;
            end
          end else begin
            pairs_left_next      = 17'd1 << mask_ones;
            shift_lock_bits_next = num[1:0];
            pair_position_next   = 2'd0;
            phase_next           = kse_pkg::PH_PAIR_SET;
          end
        end
        kse_pkg::PH_PAIR_SET: begin
          held_char_set_next = num;
          phase_next         = kse_pkg::PH_PAIR_CODE;
        end
        kse_pkg::PH_PAIR_CODE: begin
          case (cur_pair_pos)
            2'd0:    selected = 1'b1;
            2'd1:    selected = (cur_lock == kse_pkg::LOCK_SHIFT) ||
                                (cur_lock == kse_pkg::LOCK_ALPHA);
            2'd2:    selected = (cur_lock == kse_pkg::LOCK_BOTH);
            default: selected = 1'b0;
          endcase
          if (selected && cur_char_set == kse_pkg::SYMBOL_SET &&
              num[15:2] == {8'd0, kse_pkg::ARROW_BASE[7:2]}) begin
            emit_valid = 1'b1;
            emit_kind  = kse_pkg::KIND_ARROW;
            emit_slot  = kse_pkg::arrow_slot(num[1:0]);
            emit_code  = cur_key_index[7:0];
          end
          if (cur_pair_pos != 2'd3) begin
            pair_position_next = cur_pair_pos + 2'd1;
          end
          pairs_left_next = cur_pairs - 17'd1;
          if (cur_pairs == 17'd1) begin
            dec16          = cur_key_index + 16'd1;
            key_index_next = dec16;
            if (dec16 == cur_keys_total) begin
              phase_next = kse_pkg::PH_DONE;
              emit_done  = 1'b1;
            end else begin
              phase_next = kse_pkg::PH_KEY_MASK;
            end
          end else begin
            phase_next = kse_pkg::PH_PAIR_SET;
          end
        end
        default: begin
          phase_next = cur_phase;
        end
      endcase
    end

    // A completing byte without an arrow still yields an end record.
    if (emit_done && !emit_valid) begin
      emit_valid = 1'b1;
      emit_kind  = kse_pkg::KIND_END;
      emit_slot  = 4'd0;
      emit_code  = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= kse_pkg::PH_HDR_HI;
      wide_numbers      <= 1'b0;
      high_byte_pending <= 1'b0;
      held_high_byte    <= 8'd0;
      modifiers_left    <= 16'd0;
      modifier_code     <= 16'd0;
      mod_keycodes_left <= 16'd0;
      first_of_modifier <= 1'b1;
      keys_total        <= 16'd0;
      key_index         <= 16'd0;
      pairs_left        <= 17'd0;
      pair_position     <= 2'd0;
      shift_lock_bits   <= 2'd0;
      held_char_set     <= 16'd0;
    end else if (process) begin
      phase             <= phase_next;
      wide_numbers      <= wide_numbers_next;
      high_byte_pending <= high_byte_pending_next;
      held_high_byte    <= held_high_byte_next;
      modifiers_left    <= modifiers_left_next;
      modifier_code     <= modifier_code_next;
      mod_keycodes_left <= mod_keycodes_left_next;
      first_of_modifier <= first_of_modifier_next;
      keys_total        <= keys_total_next;
      key_index         <= key_index_next;
      pairs_left        <= pairs_left_next;
      pair_position     <= pair_position_next;
      shift_lock_bits   <= shift_lock_bits_next;
      held_char_set     <= held_char_set_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      record_valid <= 1'b0;
    end else if (process && emit_valid) begin
      record_valid <= 1'b1;
    end else if (!record_stall) begin
      record_valid <= 1'b0;
    end
    if (process && emit_valid) begin
      record_kind <= emit_kind;
      slot        <= emit_slot;
      keycode     <= emit_code;
      map_done    <= emit_done;
    end
  end

  a_done_parks: assert property (@(posedge clk) disable iff (rst)
    process && emit_done |=> phase == kse_pkg::PH_DONE)
    else $error("map end without parser parked in done phase");

  a_pending_wide: assert property (@(posedge clk) disable iff (rst)
    high_byte_pending |-> wide_numbers)
    else $error("high byte pending with 1-byte numbers");

  a_pairs_live: assert property (@(posedge clk) disable iff (rst)
    (phase == kse_pkg::PH_PAIR_SET || phase == kse_pkg::PH_PAIR_CODE) |->
      pairs_left != 17'd0)
    else $error("pair phase with no pairs left");

  a_end_has_done: assert property (@(posedge clk) disable iff (rst)
    record_valid && record_kind == kse_pkg::KIND_END |-> map_done)
    else $error("end record without map_done");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    process && emit_valid |-> !record_valid || !record_stall)
    else $error("record overwritten while stalled");

endmodule
